### hdl/lla_pkg.sv
// Shared types and constants for the Life-like automaton step block.
package lla_pkg;

  localparam int DIM_W  = 14;
  localparam int RULE_W = 9;
  localparam int LIVE_W = 27;
  localparam int IDX_W  = 8;
  localparam int DATA_W = 16;

  localparam logic [IDX_W-1:0] REG_ROW_WIDTH    = 8'd0;
  localparam logic [IDX_W-1:0] REG_ROW_COUNT    = 8'd1;
  localparam logic [IDX_W-1:0] REG_BIRTH_MASK   = 8'd2;
  localparam logic [IDX_W-1:0] REG_SURVIVE_MASK = 8'd3;

  localparam logic [DIM_W-1:0]  ROW_WIDTH_RST    = 14'd8000;
  localparam logic [DIM_W-1:0]  ROW_COUNT_RST    = 14'd8000;
  localparam logic [RULE_W-1:0] BIRTH_MASK_RST   = 9'd6;
  localparam logic [RULE_W-1:0] SURVIVE_MASK_RST = 9'd6;

  typedef struct packed {
    logic alive;
    logic emit;
    logic clear;
    logic last;
    logic left_ok;
    logic right_ok;
    logic top_ok;
    logic bot_ok;
  } lla_tag_t;

endpackage

### hdl/lla_position.sv
// Raster position tracker with edge flags and a serial divider for width changes.
module lla_position #(
  parameter int WW = 14,
  parameter int HW = 14,
  parameter int AW = 13,
  parameter int PW = 27
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            recalc,
  input  logic [WW-1:0]   w_eff,
  input  logic [HW-1:0]   h_eff,
  input  logic            req_type,
  input  logic            cell_value,
  output logic [AW-1:0]   col_idx,
  output lla_pkg::lla_tag_t tag,
  output logic            busy
);

  localparam int CNTW = $clog2(PW + 1);

  logic [PW-1:0]   pos;
  logic [PW-1:0]   row;
  logic [AW-1:0]   col;
  logic [PW-1:0]   div_q;
  logic [WW-1:0]   div_rem;
  logic [CNTW-1:0] cnt;

  logic [AW-1:0]   wm1;
  logic            col_zero;
  logic [AW-1:0]   cc;
  logic [PW-1:0]   rc;
  logic [PW-1:0]   h_ext;
  logic            pre;
  logic            over;
  logic            last;
  logic [WW:0]     rem_sh;
  logic [WW:0]     rem_sub;
  logic            ge;
  logic [WW-1:0]   rem_next;
  logic [PW-1:0]   q_next;

  assign wm1      = AW'(w_eff - WW'(1));
  assign col_zero = (col == '0);
  assign cc       = col_zero ? wm1 : col - AW'(1);
  assign rc       = row - PW'(1) - PW'(col_zero);
  assign h_ext    = PW'(h_eff);
  assign pre      = (row == '0) || ((row == PW'(1)) && col_zero);
  assign over     = (rc >= h_ext);
  assign last     = (rc == h_ext - PW'(1)) && (cc == wm1);

  always_comb begin
    tag.alive    = !req_type && cell_value && (row < h_ext);
    tag.emit     = !pre && !over;
    tag.clear    = !pre && (over || last);
    tag.last     = !pre && last;
    tag.left_ok  = (cc != '0);
    tag.right_ok = (cc != wm1);
    tag.top_ok   = (rc != '0);
    tag.bot_ok   = (rc != h_ext - PW'(1));
  end

  assign col_idx = col;
  assign busy    = recalc || (cnt != '0);

  assign rem_sh   = {div_rem, div_q[PW-1]};
  assign ge       = (rem_sh >= {1'b0, w_eff});
  assign rem_sub  = rem_sh - {1'b0, w_eff};
  assign rem_next = ge ? rem_sub[WW-1:0] : rem_sh[WW-1:0];
  assign q_next   = {div_q[PW-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      row     <= '0;
      col     <= '0;
      cnt     <= '0;
      div_q   <= '0;
      div_rem <= '0;
    end else if (recalc) begin
      div_q   <= pos;
      div_rem <= '0;
      cnt     <= CNTW'(PW);
    end else if (cnt != '0) begin
      div_q   <= q_next;
      div_rem <= rem_next;
      cnt     <= cnt - CNTW'(1);
      if (cnt == CNTW'(1)) begin
        col <= AW'(rem_next);
        row <= q_next;
      end
    end else if (adv) begin
      if (tag.clear) begin
        pos <= '0;
        row <= '0;
        col <= '0;
      end else begin
        pos <= pos + PW'(1);
        if (col == wm1) begin
          col <= '0;
          row <= row + PW'(1);
        end else begin
          col <= col + AW'(1);
        end
      end
    end
  end

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    adv && !busy && tag.clear |=> (pos == '0) && (col == '0) && (row == '0))
    else $error("position not cleared at end of generation");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    adv && !busy && !tag.clear |=> pos == $past(pos) + PW'(1))
    else $error("position did not advance by one");

  a_no_emit_pre: assert property (@(posedge clk) disable iff (rst)
    pre |-> !tag.emit && !tag.clear)
    else $error("result flagged before the window is filled");

endmodule

### hdl/lla_stage.sv
// Line buffers, 3x3 window, rule lookup, running count and result register.
module lla_stage #(
  parameter int AW    = 13,
  parameter int DEPTH = 8192
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic [AW-1:0]                 col_idx,
  input  lla_pkg::lla_tag_t             tag,
  input  logic [lla_pkg::RULE_W-1:0]    birth_mask,
  input  logic [lla_pkg::RULE_W-1:0]    survive_mask,
  input  logic                          out_stall,
  output logic                          take,
  output logic                          out_valid,
  output logic                          next_cell,
  output logic [lla_pkg::LIVE_W-1:0]    live_total,
  output logic                          frame_last
);

  logic upper_mem  [DEPTH];
  logic middle_mem [DEPTH];

  logic                       s1_valid;
  lla_pkg::lla_tag_t          s1_tag;
  logic [AW-1:0]              s1_idx;
  logic                       top_q;
  logic                       mid_q;
  logic [8:0]                 win;
  logic [lla_pkg::LIVE_W-1:0] live;

  logic                       s1_go;
  logic [8:0]                 win_next;
  logic [3:0]                 n;
  logic                       nxt;
  logic [lla_pkg::LIVE_W-1:0] live_next;
  logic                       l;
  logic                       r;

  assign s1_go = s1_valid && (!s1_tag.emit || !out_valid || !out_stall);
  assign take  = !s1_valid || s1_go;

  assign win_next = {s1_tag.alive, mid_q, top_q, win[8:3]};
  assign l = s1_tag.left_ok;
  assign r = s1_tag.right_ok;

  always_comb begin
    n = 4'(win_next[3] & s1_tag.top_ok)
      + 4'(win_next[0] & s1_tag.top_ok & l)
      + 4'(win_next[6] & s1_tag.top_ok & r)
      + 4'(win_next[1] & l)
      + 4'(win_next[7] & r)
      + 4'(win_next[5] & s1_tag.bot_ok)
      + 4'(win_next[2] & s1_tag.bot_ok & l)
      + 4'(win_next[8] & s1_tag.bot_ok & r);
    nxt = win_next[4] ? survive_mask[n] : birth_mask[n];
  end

  assign live_next = live + lla_pkg::LIVE_W'(nxt);

  always_ff @(posedge clk) begin
    if (adv) begin
      top_q <= upper_mem[col_idx];
      mid_q <= middle_mem[col_idx];
    end
    if (s1_go) begin
      upper_mem[s1_idx]  <= mid_q;
      middle_mem[s1_idx] <= s1_tag.alive;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag <= tag;
      s1_idx <= col_idx;
    end
    if (s1_go && s1_tag.emit) begin
      next_cell  <= nxt;
      live_total <= live_next;
      frame_last <= s1_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      win       <= '0;
      live      <= '0;
    end else begin
      if (adv) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go && s1_tag.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (s1_go) begin
        win <= win_next;
        if (s1_tag.clear) begin
          live <= '0;
        end else if (s1_tag.emit) begin
          live <= live_next;
        end
      end
    end
  end

  a_take: assert property (@(posedge clk) disable iff (rst)
    adv |-> take)
    else $error("item taken while the stage is held");

  a_emit_out: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_tag.emit |=> out_valid)
    else $error("emitted cell not presented");

  a_live_clear: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_tag.clear |=> live == '0)
    else $error("live count not cleared at end of generation");

endmodule

### hdl/life_like_automaton_step.sv
// Top level of the Life-like automaton generation step.
// Usage: grid cells arrive in raster order on the item channel (item_valid,
// item_stall, req_type, cell_value); after row_count*row_width cells the host
// sends row_width+1 drain items. From the item at stream index row_width+1
// onward each transfer yields the next state of the cell row_width+1 places
// back on the result channel (result_valid, result_stall, next_cell,
// live_total, frame_last); frame_last marks the final cell of a generation.
// Throughput is one item per cycle while item_stall is low. The pipeline is
// an input stage reading both line buffers and feeding the window/rule
// logic, then the result register; while the result register is stalled
// the input stage still takes one more item.
// Registers are written on the cfg channel; a row_width write retimes the
// raster column and row from the stream position with a one-bit-per-cycle
// divider, holding item_stall high in the write cycle and until the divider
// has produced every stream position bit.
// Reset restores the default rule (born or survive on one or two
// neighbours), an 8000 by 8000 grid and a zero stream position; the line
// buffers are not cleared, as entries are always written before they count.
module life_like_automaton_step #(
  parameter int MAX_WIDTH  = 8192,
  parameter int MAX_HEIGHT = 8192
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          req_type,
  input  logic                          cell_value,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          next_cell,
  output logic [lla_pkg::LIVE_W-1:0]    live_total,
  output logic                          frame_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lla_pkg::IDX_W-1:0]     cfg_index,
  input  logic [lla_pkg::DATA_W-1:0]    cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam longint unsigned POS_MAX =
    longint'(MAX_WIDTH) * longint'(MAX_HEIGHT) + longint'(MAX_WIDTH);
  localparam int PW = $clog2(POS_MAX + 1);
  localparam int CWW = (WW > lla_pkg::DIM_W) ? WW : lla_pkg::DIM_W;
  localparam int CHW = (HW > lla_pkg::DIM_W) ? HW : lla_pkg::DIM_W;

  logic [lla_pkg::DIM_W-1:0]  row_width;
  logic [lla_pkg::DIM_W-1:0]  row_count;
  logic [lla_pkg::RULE_W-1:0] birth_mask;
  logic [lla_pkg::RULE_W-1:0] survive_mask;

  logic              cfg_wr;
  logic              recalc;
  logic [CWW-1:0]    w_wide;
  logic [CHW-1:0]    h_wide;
  logic [WW-1:0]     w_eff;
  logic [HW-1:0]     h_eff;
  logic              adv;
  logic              busy;
  logic              take;
  logic [AW-1:0]     col_idx;
  lla_pkg::lla_tag_t tag;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign recalc    = cfg_wr && (cfg_index == lla_pkg::REG_ROW_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width    <= lla_pkg::ROW_WIDTH_RST;
      row_count    <= lla_pkg::ROW_COUNT_RST;
      birth_mask   <= lla_pkg::BIRTH_MASK_RST;
      survive_mask <= lla_pkg::SURVIVE_MASK_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        lla_pkg::REG_ROW_WIDTH:    row_width    <= cfg_data[lla_pkg::DIM_W-1:0];
        lla_pkg::REG_ROW_COUNT:    row_count    <= cfg_data[lla_pkg::DIM_W-1:0];
        lla_pkg::REG_BIRTH_MASK:   birth_mask   <= cfg_data[lla_pkg::RULE_W-1:0];
        lla_pkg::REG_SURVIVE_MASK: survive_mask <= cfg_data[lla_pkg::RULE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (CWW'(row_width) < CWW'(2)) begin
      w_wide = CWW'(2);
    end else if (CWW'(row_width) > CWW'(MAX_WIDTH)) begin
      w_wide = CWW'(MAX_WIDTH);
    end else begin
      w_wide = CWW'(row_width);
    end
    priority if (CHW'(row_count) < CHW'(1)) begin
      h_wide = CHW'(1);
    end else if (CHW'(row_count) > CHW'(MAX_HEIGHT)) begin
      h_wide = CHW'(MAX_HEIGHT);
    end else begin
      h_wide = CHW'(row_count);
    end
  end

  assign w_eff = WW'(w_wide);
  assign h_eff = HW'(h_wide);

  assign item_stall = busy || !take;
  assign adv        = item_valid && !item_stall;

  lla_position #(
    .WW (WW),
    .HW (HW),
    .AW (AW),
    .PW (PW)
  ) u_position (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .recalc     (recalc),
    .w_eff      (w_eff),
    .h_eff      (h_eff),
    .req_type   (req_type),
    .cell_value (cell_value),
    .col_idx    (col_idx),
    .tag        (tag),
    .busy       (busy)
  );

  lla_stage #(
    .AW    (AW),
    .DEPTH (MAX_WIDTH)
  ) u_stage (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .col_idx      (col_idx),
    .tag          (tag),
    .birth_mask   (birth_mask),
    .survive_mask (survive_mask),
    .out_stall    (result_stall),
    .take         (take),
    .out_valid    (result_valid),
    .next_cell    (next_cell),
    .live_total   (live_total),
    .frame_last   (frame_last)
  );

endmodule

### verif/tb_life_like_automaton_step.sv
// Testbench for the Life-like automaton step: streamed grids checked against a cell predictor.
module tb_life_like_automaton_step;

  localparam int MAX_COLS = 8192;
  localparam int MAX_ROWS = 8192;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CUT_ITEMS = 150;
  localparam logic REQ_CELL  = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;
  localparam logic [lla_pkg::IDX_W-1:0] REG_UNUSED_LOW = 8'd4;
  localparam logic [lla_pkg::IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;

  typedef struct {
    bit                       alive;
    bit [lla_pkg::LIVE_W-1:0] total;
    bit                       last;
  } cell_outcome_t;

  class generation_scoreboard;
    bit [lla_pkg::DIM_W-1:0]  row_width;
    bit [lla_pkg::DIM_W-1:0]  row_count;
    bit [lla_pkg::RULE_W-1:0] birth_mask;
    bit [lla_pkg::RULE_W-1:0] survive_mask;
    bit                       line_above [MAX_COLS];
    bit                       line_centre [MAX_COLS];
    bit [8:0]                 window;
    longint unsigned          position;
    bit [lla_pkg::LIVE_W-1:0] live_count;
    cell_outcome_t            expected_cells [$];
    int unsigned              checked;
    int unsigned              mismatches;
    int unsigned              live_seen;
    int unsigned              frames;

    function new();
      row_width    = lla_pkg::ROW_WIDTH_RST;
      row_count    = lla_pkg::ROW_COUNT_RST;
      birth_mask   = lla_pkg::BIRTH_MASK_RST;
      survive_mask = lla_pkg::SURVIVE_MASK_RST;
      window       = '0;
      position     = 0;
      live_count   = '0;
    endfunction

    function longint unsigned cols();
      if (row_width < 2) return 2;
      if (row_width > MAX_COLS) return MAX_COLS;
      return row_width;
    endfunction

    function longint unsigned rows();
      if (row_count < 1) return 1;
      if (row_count > MAX_ROWS) return MAX_ROWS;
      return row_count;
    endfunction

    function bit in_grid();
      return position < cols() * rows();
    endfunction

    function int unsigned pending();
      return expected_cells.size();
    endfunction

    function void write_reg(logic [lla_pkg::IDX_W-1:0] idx,
                            logic [lla_pkg::DATA_W-1:0] data);
      case (idx)
        lla_pkg::REG_ROW_WIDTH:    row_width    = data[lla_pkg::DIM_W-1:0];
        lla_pkg::REG_ROW_COUNT:    row_count    = data[lla_pkg::DIM_W-1:0];
        lla_pkg::REG_BIRTH_MASK:   birth_mask   = data[lla_pkg::RULE_W-1:0];
        lla_pkg::REG_SURVIVE_MASK: survive_mask = data[lla_pkg::RULE_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_cell(logic kind, logic value);
      longint unsigned w, h, cells, c, rc, cc;
      int unsigned     j, n;
      bit              v, top, mid, centre, next_state;
      bit              left_ok, right_ok, top_ok, bot_ok;
      cell_outcome_t   outcome;
      w     = cols();
      h     = rows();
      cells = w * h;
      v     = (kind == REQ_CELL && position < cells) ? value : 1'b0;
      j     = 32'(position % w);
      top   = line_above[j];
      mid   = line_centre[j];
      line_above[j]  = mid;
      line_centre[j] = v;
      window = {v, mid, top, window[8:3]};
      if (position < w + 1) begin
        position++;
        return;
      end
      c = position - w - 1;
      if (c >= cells) begin
        position   = 0;
        live_count = '0;
        return;
      end
      rc       = c / w;
      cc       = c % w;
      left_ok  = cc >= 1;
      right_ok = cc + 2 <= w;
      top_ok   = rc >= 1;
      bot_ok   = rc + 1 < h;
      n = 0;
      if (top_ok)
        n += int'(left_ok & window[0]) + int'(window[3]) + int'(right_ok & window[6]);
      n += int'(left_ok & window[1]) + int'(right_ok & window[7]);
      if (bot_ok)
        n += int'(left_ok & window[2]) + int'(window[5]) + int'(right_ok & window[8]);
      centre     = window[4];
      next_state = centre ? survive_mask[n] : birth_mask[n];
      live_count = live_count + next_state;
      outcome.alive = next_state;
      outcome.total = live_count;
      outcome.last  = (c == cells - 1);
      expected_cells.insert(expected_cells.size(), outcome);
      if (outcome.last) begin
        position   = 0;
        live_count = '0;
      end else begin
        position++;
      end
    endfunction

    function void check_cell(logic alive, logic [lla_pkg::LIVE_W-1:0] total, logic last);
      cell_outcome_t want;
      if (expected_cells.size() == 0) begin
        $error("result transfer with nothing pending: next_cell %b live_total %0d",
               alive, total);
        mismatches++;
        return;
      end
      want = expected_cells.pop_front();
      checked++;
      if (alive !== want.alive) begin
        $error("next_cell: expected %0d, got %0d", want.alive, alive);
        mismatches++;
      end
      if (total !== want.total) begin
        $error("live_total: expected %0d, got %0d", want.total, total);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("frame_last: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
      if (want.alive) live_seen++;
      if (want.last) frames++;
    endfunction
  endclass

  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       item_valid   = 1'b0;
  logic                       item_stall;
  logic                       req_type     = REQ_CELL;
  logic                       cell_value   = 1'b0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic                       next_cell;
  logic [lla_pkg::LIVE_W-1:0] live_total;
  logic                       frame_last;
  logic                       cfg_valid    = 1'b0;
  logic                       cfg_ready;
  logic [lla_pkg::IDX_W-1:0]  cfg_index    = '0;
  logic [lla_pkg::DATA_W-1:0] cfg_data     = '0;

  generation_scoreboard sb;
  int unsigned          items_sent = 0;

  life_like_automaton_step #(
    .MAX_WIDTH  (MAX_COLS),
    .MAX_HEIGHT (MAX_ROWS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .req_type     (req_type),
    .cell_value   (cell_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .next_cell    (next_cell),
    .live_total   (live_total),
    .frame_last   (frame_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_cell(next_cell, live_total, frame_last);
  end

  initial begin : result_pacing
    int unsigned hold_left;
    int unsigned free_left;
    int unsigned pick;
    bit          held_back;
    hold_left = 0;
    free_left = 0;
    held_back = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_back && sb.checked >= 300) begin
        held_back = 1'b1;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= 1'b0;
        if (free_left != 0) begin
          free_left--;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 45) hold_left = $urandom_range(1, 3);
          else if (pick < 50) hold_left = $urandom_range(8, 30);
          else if (pick < 60) free_left = $urandom_range(20, 150);
        end
      end
    end
  end

  initial begin : watchdog
    #80_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input logic kind, input logic value, input int unsigned gap);
    item_valid <= 1'b1;
    req_type   <= kind;
    cell_value <= value;
    do @(posedge clk); while (item_stall);
    sb.note_cell(kind, value);
    items_sent++;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [lla_pkg::IDX_W-1:0] idx,
                           input logic [lla_pkg::DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic set_rule(input logic [lla_pkg::DATA_W-1:0] width,
                          input logic [lla_pkg::DATA_W-1:0] count,
                          input logic [lla_pkg::DATA_W-1:0] birth,
                          input logic [lla_pkg::DATA_W-1:0] survive,
                          input bit [3:0] pick);
    if (pick[0]) write_reg(lla_pkg::REG_ROW_WIDTH, width);
    if (pick[1]) write_reg(lla_pkg::REG_ROW_COUNT, count);
    if (pick[2]) write_reg(lla_pkg::REG_BIRTH_MASK, birth);
    if (pick[3]) write_reg(lla_pkg::REG_SURVIVE_MASK, survive);
    if (pick != 0) cfg_valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // advance the stream until the generation closes, or until cut items have gone
  task automatic run_frame(input int unsigned density, input bit gapless, input bit noisy,
                           input int unsigned cut);
    int unsigned sent;
    logic        kind;
    logic        value;
    sent = 0;
    do begin
      if (sb.in_grid()) begin
        kind  = (noisy && $urandom_range(0, 19) == 0) ? REQ_DRAIN : REQ_CELL;
        value = ($urandom_range(0, 99) < density);
      end else begin
        kind  = (noisy && $urandom_range(0, 9) == 0) ? REQ_CELL : REQ_DRAIN;
        value = 1'($urandom_range(0, 1));
      end
      send_item(kind, value, gapless ? 0 : pick_gap());
      sent++;
    end while (sb.position != 0 && sent != cut);
  endtask

  function automatic logic [lla_pkg::DATA_W-1:0] pick_mask();
    int unsigned pick;
    logic [lla_pkg::DATA_W-1:0] junk;
    pick = $urandom_range(0, 99);
    junk = lla_pkg::DATA_W'($urandom_range(0, 127)) << lla_pkg::RULE_W;
    if (pick < 15) return junk;
    if (pick < 30) return junk | lla_pkg::DATA_W'(9'h1FF);
    return junk | lla_pkg::DATA_W'($urandom_range(0, 511));
  endfunction

  initial begin : stimulus
    int unsigned                random_start;
    int unsigned                pick;
    int unsigned                frame_len;
    logic [lla_pkg::DATA_W-1:0] width;
    logic [lla_pkg::DATA_W-1:0] count;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 8; i++)
      send_item(i == 5 ? REQ_DRAIN : REQ_CELL, i[0] ^ i[1], pick_gap());
    wait_quiet();
    // shrink the grid under the live stream position
    write_reg(lla_pkg::REG_ROW_WIDTH, 16'hC000);
    write_reg(lla_pkg::REG_ROW_COUNT, 16'h0000);
    write_reg(lla_pkg::REG_BIRTH_MASK, 16'hFFFF);
    write_reg(lla_pkg::REG_SURVIVE_MASK, 16'hFE00);
    write_reg(REG_UNUSED_LOW, 16'h0005);
    write_reg(REG_UNUSED_TOP, 16'hFFFF);
    cfg_valid <= 1'b0;
    run_frame(50, 1'b0, 1'b0, 0);
    wait_quiet();
    send_item(REQ_CELL, 1'b1, pick_gap());
    send_item(REQ_DRAIN, 1'b1, pick_gap());
    send_item(REQ_CELL, 1'b1, pick_gap());
    send_item(REQ_DRAIN, 1'b1, pick_gap());
    send_item(REQ_DRAIN, 1'b0, pick_gap());
    wait_quiet();
    set_rule(16'd3, 16'd3, 16'h0000, 16'h0128, 4'hF);
    for (int i = 0; i < 13; i++)
      send_item(i < 9 ? REQ_CELL : REQ_DRAIN, 1'b1, 0);

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        width = lla_pkg::DATA_W'($urandom_range(0, 2));
        count = lla_pkg::DATA_W'($urandom_range(0, 10));
      end else if (pick < 15) begin
        width = lla_pkg::DATA_W'($urandom_range(13, 40));
        count = lla_pkg::DATA_W'($urandom_range(0, 3));
      end else begin
        width = lla_pkg::DATA_W'($urandom_range(2, 12));
        count = lla_pkg::DATA_W'($urandom_range(0, 10));
      end
      width = width | (lla_pkg::DATA_W'($urandom_range(0, 3)) << lla_pkg::DIM_W);
      count = count | (lla_pkg::DATA_W'($urandom_range(0, 3)) << lla_pkg::DIM_W);
      wait_quiet();
      set_rule(width, count, pick_mask(), pick_mask(), 4'($urandom_range(1, 15)));
      if ($urandom_range(0, 99) < 15) begin
        frame_len = 32'(sb.cols() * sb.rows() + sb.cols() + 1);
        run_frame($urandom_range(0, 100), $urandom_range(0, 3) == 0,
                  $urandom_range(0, 4) == 0, $urandom_range(1, frame_len - 1));
        if (sb.position != 0) begin
          wait_quiet();
          set_rule('0, 16'($urandom_range(0, 10)), pick_mask(), pick_mask(),
                   {3'($urandom_range(1, 7)), 1'b0});
        end
      end
      run_frame($urandom_range(0, 100), $urandom_range(0, 3) == 0,
                $urandom_range(0, 4) == 0, 0);
    end

    // widest grid: cut short, then close it by narrowing the rows
    wait_quiet();
    set_rule(16'h3FFF, 16'd1, pick_mask(), pick_mask(), 4'hF);
    run_frame($urandom_range(20, 80), 1'b0, 1'b1, CUT_ITEMS);
    wait_quiet();
    set_rule(16'd2, 16'd1, pick_mask(), pick_mask(), 4'h3);
    run_frame(50, 1'b0, 1'b0, 0);
    // tallest grid: cut short, then close it by dropping the row count
    wait_quiet();
    set_rule(16'd2, 16'h2000, pick_mask(), pick_mask(), 4'hF);
    run_frame($urandom_range(20, 80), 1'b0, 1'b1, CUT_ITEMS);
    wait_quiet();
    set_rule('0, 16'd1, pick_mask(), pick_mask(), 4'h2);
    run_frame(50, 1'b0, 1'b0, 0);
    wait_quiet();

    $display("Sent %0d items; checked %0d cells over %0d generations, %0d of them alive.",
             items_sent, sb.checked, sb.frames, sb.live_seen);
    $display("Dimension writes hit both clamps; the widest and tallest grids were cut short.");
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
